// File: sv/keypad_pwm_setpoint_entry_defines.svh
// Assertion macros for the port-level checker of the keypad set-point entry block.
// Expect clk and arst_n in scope where used.
`ifndef KEYPAD_PWM_SETPOINT_ENTRY_DEFINES_SVH
`define KEYPAD_PWM_SETPOINT_ENTRY_DEFINES_SVH

// implication in the same cycle
`define CHK_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// implication in the following cycle
`define CHK_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// File: sv/kpse_pkg.sv
// Shared types, codes and lookup functions of the keypad set-point entry block.
// No dependencies.
package kpse_pkg;

	localparam int KEY_BITS = 5;
	localparam int NUM_BITS = 24;
	localparam int FIELD_BITS = 24;
	localparam int PCT_BITS = 7;

	localparam logic [KEY_BITS-1:0] KEY_NONE = 5'd0;
	localparam logic [KEY_BITS-1:0] KEY_LAST = 5'd16;

	localparam logic [NUM_BITS-1:0] NUMERATOR_RESET = 24'd327656;
	localparam logic [PCT_BITS-1:0] PERCENT = 7'd100;
	localparam logic [3:0] DUTY_STEP = 4'd10;

	localparam logic [3:0] CODE_DIGIT_LAST = 4'd9;
	localparam logic [3:0] CODE_TOGGLE_FIRST = 4'd10;
	localparam logic [3:0] CODE_TOGGLE_LAST = 4'd13;
	localparam logic [3:0] CODE_DOUBLE = 4'd14;
	localparam logic [3:0] CODE_RAISE = 4'd15;

	localparam logic [1:0] SLOT_FREQ_ONE = 2'd0;
	localparam logic [1:0] SLOT_DUTY_ONE = 2'd1;
	localparam logic [1:0] SLOT_FREQ_TWO = 2'd2;
	localparam logic [1:0] SLOT_DUTY_TWO = 2'd3;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	typedef enum logic [1:0] {
		ECHO_NONE   = 2'd0,
		ECHO_CURSOR = 2'd1,
		ECHO_DIGIT  = 2'd2
	} echo_kind_t;

	function automatic logic [3:0] key_map(input logic [3:0] idx);
		logic [3:0] code;
		case (idx)
			4'd0:    code = 4'd1;
			4'd1:    code = 4'd2;
			4'd2:    code = 4'd3;
			4'd3:    code = 4'd10;
			4'd4:    code = 4'd4;
			4'd5:    code = 4'd5;
			4'd6:    code = 4'd6;
			4'd7:    code = 4'd11;
			4'd8:    code = 4'd7;
			4'd9:    code = 4'd8;
			4'd10:   code = 4'd9;
			4'd11:   code = 4'd12;
			4'd12:   code = 4'd14;
			4'd13:   code = 4'd0;
			4'd14:   code = 4'd15;
			default: code = 4'd13;
		endcase
		return code;
	endfunction

	function automatic logic [7:0] cursor_addr(input logic [1:0] slot);
		logic [7:0] addr;
		case (slot)
			SLOT_FREQ_ONE: addr = 8'h83;
			SLOT_DUTY_ONE: addr = 8'h8D;
			SLOT_FREQ_TWO: addr = 8'hC3;
			default:       addr = 8'hCD;
		endcase
		return addr;
	endfunction

endpackage

// File: sv/kpse_ctrl.sv
// Key decode, entry accumulator and the four stored settings.
// Depends on kpse_pkg.
module kpse_ctrl #(
	parameter int VALUE_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [kpse_pkg::KEY_BITS-1:0] key_code,
	output logic [VALUE_BITS-1:0]         freq_one,
	output logic [VALUE_BITS-1:0]         duty_one,
	output logic [VALUE_BITS-1:0]         freq_two,
	output logic [VALUE_BITS-1:0]         duty_two,
	output kpse_pkg::echo_kind_t          echo_kind,
	output logic [7:0]                    echo_value
);
	import kpse_pkg::*;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	logic [3:0]            flags_q;
	logic [VALUE_BITS-1:0] entry_q;
	logic [VALUE_BITS-1:0] set_q [4];
	echo_kind_t            echo_kind_q;
	logic [7:0]            echo_value_q;

	logic                  key_hit;
	logic [3:0]            code;
	logic [1:0]            slot;
	logic [VALUE_BITS+3:0] entry_ext;
	logic [VALUE_BITS+3:0] times_ten;
	logic [VALUE_BITS-1:0] entry_digit;
	logic [VALUE_BITS:0]   raise_one;
	logic [VALUE_BITS:0]   raise_two;
	logic [VALUE_BITS-1:0] duty_one_up;
	logic [VALUE_BITS-1:0] duty_two_up;
	logic [VALUE_BITS-1:0] freq_one_dbl;
	logic [VALUE_BITS-1:0] freq_two_dbl;

	assign key_hit = (key_code != KEY_NONE) && (key_code <= KEY_LAST);
	assign code = key_map(4'(key_code - 5'd1));
	assign slot = 2'(code - CODE_TOGGLE_FIRST);

	assign entry_ext = (VALUE_BITS+4)'(entry_q);
	assign times_ten = (entry_ext << 3) + (entry_ext << 1) + (VALUE_BITS+4)'(code);
	assign entry_digit = (times_ten[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? VALUE_MAX
		: times_ten[VALUE_BITS-1:0];

	assign raise_one = (VALUE_BITS+1)'(set_q[SLOT_DUTY_ONE]) + (VALUE_BITS+1)'(DUTY_STEP);
	assign raise_two = (VALUE_BITS+1)'(set_q[SLOT_DUTY_TWO]) + (VALUE_BITS+1)'(DUTY_STEP);
	assign duty_one_up = raise_one[VALUE_BITS] ? VALUE_MAX : raise_one[VALUE_BITS-1:0];
	assign duty_two_up = raise_two[VALUE_BITS] ? VALUE_MAX : raise_two[VALUE_BITS-1:0];

	assign freq_one_dbl = set_q[SLOT_FREQ_ONE][VALUE_BITS-1] ? VALUE_MAX
		: {set_q[SLOT_FREQ_ONE][VALUE_BITS-2:0], 1'b0};
	assign freq_two_dbl = set_q[SLOT_FREQ_TWO][VALUE_BITS-1] ? VALUE_MAX
		: {set_q[SLOT_FREQ_TWO][VALUE_BITS-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q      <= '0;
			entry_q      <= '0;
			set_q[0]     <= '0;
			set_q[1]     <= '0;
			set_q[2]     <= '0;
			set_q[3]     <= '0;
			echo_kind_q  <= ECHO_NONE;
			echo_value_q <= '0;
		end else if (take) begin
			echo_kind_q  <= ECHO_NONE;
			echo_value_q <= '0;
			if (key_hit) begin
				case (code) inside
					[CODE_TOGGLE_FIRST:CODE_TOGGLE_LAST]: begin
						if (flags_q[slot]) begin
							set_q[slot] <= entry_q;
						end else begin
							entry_q      <= '0;
							echo_kind_q  <= ECHO_CURSOR;
							echo_value_q <= cursor_addr(slot);
						end
						flags_q[slot] <= ~flags_q[slot];
					end
					CODE_DOUBLE: begin
						set_q[SLOT_FREQ_ONE] <= freq_one_dbl;
						set_q[SLOT_FREQ_TWO] <= freq_two_dbl;
					end
					CODE_RAISE: begin
						set_q[SLOT_DUTY_ONE] <= duty_one_up;
						set_q[SLOT_DUTY_TWO] <= duty_two_up;
					end
					default: begin
						if (code <= CODE_DIGIT_LAST && flags_q != 4'd0) begin
							entry_q      <= entry_digit;
							echo_kind_q  <= ECHO_DIGIT;
							echo_value_q <= ASCII_ZERO | {4'd0, code};
						end
					end
				endcase
			end
		end
	end

	assign freq_one   = set_q[SLOT_FREQ_ONE];
	assign duty_one   = set_q[SLOT_DUTY_ONE];
	assign freq_two   = set_q[SLOT_FREQ_TWO];
	assign duty_two   = set_q[SLOT_DUTY_TWO];
	assign echo_kind  = echo_kind_q;
	assign echo_value = echo_value_q;

endmodule

// File: sv/kpse_div.sv
// Bit-serial restoring divider: one quotient bit per cycle through a shift register.
// Saturates to all ones on overflow, gives 0 for a zero divisor. Depends on kpse_pkg.
module kpse_div #(
	parameter int DVD_BITS = 24,
	parameter int DEN_BITS = 20,
	parameter int Q_BITS   = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0] divisor,
	output logic                busy,
	output logic [Q_BITS-1:0]   quotient
);
	import kpse_pkg::*;

	localparam int EXT_BITS = (DVD_BITS > Q_BITS) ? DVD_BITS : Q_BITS + 1;
	localparam int HI_BITS  = EXT_BITS - Q_BITS;
	localparam int CMP_BITS = (HI_BITS > DEN_BITS) ? HI_BITS : DEN_BITS;
	localparam int CNT_BITS = $clog2(Q_BITS + 1);

	logic [EXT_BITS-1:0] ext;
	logic [HI_BITS-1:0]  hi;
	logic                over;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   diff;
	logic                ge;

	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [Q_BITS-1:0]   sh_q;
	logic                zero_q;
	logic                sat_q;

	assign ext  = EXT_BITS'(dividend);
	assign hi   = ext[EXT_BITS-1:Q_BITS];
	assign over = CMP_BITS'(hi) >= CMP_BITS'(divisor);

	assign trial = {rem_q, sh_q[Q_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(Q_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= divisor;
			rem_q  <= over ? '0 : DEN_BITS'(hi);
			sh_q   <= ext[Q_BITS-1:0];
			zero_q <= divisor == '0;
			sat_q  <= over;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
			sh_q  <= {sh_q[Q_BITS-2:0], ge};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = zero_q ? '0 : (sat_q ? '1 : sh_q);

endmodule

// File: sv/keypad_pwm_setpoint_entry.sv
// Keypad set-point entry for two PWM channels.
// Depends on kpse_pkg, kpse_ctrl and kpse_div.
//
// Usage:
//   key channel: key_code with key_valid/key_ready. One transfer per key event;
//     a code of 0 or above 16 changes nothing but still yields a result.
//   result channel: period/compare counts for both channels plus the display
//     echo, with result_valid/result_ready. Exactly one result per key.
//   cfg_write/cfg_data load count_numerator; write only while the block is idle.
// Sequence: the key updates the settings at its transfer; the products are then
//   registered, four bit-serial dividers are loaded and run side by side, and
//   the result is registered once all dividers are done and no held result
//   blocks the output. A new key is taken only after the result of the last
//   key has been registered.
// Reset clears all settings, the open entries, the entry value and the result
//   valid flag, and loads count_numerator with 327656.
// A stalled receiver holds the result; the next key is still taken and worked
//   out, then waits until the held result transfers.
module keypad_pwm_setpoint_entry #(
	parameter int VALUE_BITS = 20,
	parameter int COUNT_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [kpse_pkg::NUM_BITS-1:0]   cfg_data,
	input  logic                            key_valid,
	output logic                            key_ready,
	input  logic [kpse_pkg::KEY_BITS-1:0]   key_code,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [kpse_pkg::FIELD_BITS-1:0] period_one,
	output logic [kpse_pkg::FIELD_BITS-1:0] compare_one,
	output logic [kpse_pkg::FIELD_BITS-1:0] period_two,
	output logic [kpse_pkg::FIELD_BITS-1:0] compare_two,
	output logic [1:0]                      echo_kind,
	output logic [7:0]                      echo_value
);
	import kpse_pkg::*;

	localparam int PROD_BITS = NUM_BITS + VALUE_BITS;
	localparam int DEN_BITS  = VALUE_BITS + PCT_BITS;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_LOAD = 4'b0100,
		ST_RUN  = 4'b1000
	} state_t;

	state_t state_q;

	logic [NUM_BITS-1:0]   num_q;
	logic                  take;
	logic                  start;
	logic                  any_busy;
	logic                  load;

	logic [VALUE_BITS-1:0] freq_one;
	logic [VALUE_BITS-1:0] duty_one;
	logic [VALUE_BITS-1:0] freq_two;
	logic [VALUE_BITS-1:0] duty_two;
	echo_kind_t            echo_kind_c;
	logic [7:0]            echo_value_c;

	logic [PROD_BITS-1:0]  nd_one_s1;
	logic [PROD_BITS-1:0]  nd_two_s1;
	logic [DEN_BITS-1:0]   dn_one_s1;
	logic [DEN_BITS-1:0]   dn_two_s1;

	logic [COUNT_BITS-1:0] per_one;
	logic [COUNT_BITS-1:0] cmp_one;
	logic [COUNT_BITS-1:0] per_two;
	logic [COUNT_BITS-1:0] cmp_two;
	logic [3:0]            busy;

	logic                  result_valid_q;
	logic [FIELD_BITS-1:0] period_one_q;
	logic [FIELD_BITS-1:0] compare_one_q;
	logic [FIELD_BITS-1:0] period_two_q;
	logic [FIELD_BITS-1:0] compare_two_q;
	echo_kind_t            echo_kind_q;
	logic [7:0]            echo_value_q;

	assign key_ready = state_q == ST_IDLE;
	assign take      = key_valid && key_ready;
	assign start     = state_q == ST_LOAD;
	assign any_busy  = busy != 4'd0;
	assign load      = (state_q == ST_RUN) && !any_busy && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUMERATOR_RESET;
		end else if (cfg_write) begin
			num_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (take) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_RUN;
				ST_RUN:  if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	kpse_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.key_code  (key_code),
		.freq_one  (freq_one),
		.duty_one  (duty_one),
		.freq_two  (freq_two),
		.duty_two  (duty_two),
		.echo_kind (echo_kind_c),
		.echo_value(echo_value_c)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			nd_one_s1 <= PROD_BITS'(num_q) * PROD_BITS'(duty_one);
			nd_two_s1 <= PROD_BITS'(num_q) * PROD_BITS'(duty_two);
			dn_one_s1 <= DEN_BITS'(freq_one) * DEN_BITS'(PERCENT);
			dn_two_s1 <= DEN_BITS'(freq_two) * DEN_BITS'(PERCENT);
		end
	end

	kpse_div #(
		.DVD_BITS(NUM_BITS), .DEN_BITS(VALUE_BITS), .Q_BITS(COUNT_BITS)
	) u_per_one (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(num_q),
		.divisor(freq_one), .busy(busy[0]), .quotient(per_one)
	);

	kpse_div #(
		.DVD_BITS(PROD_BITS), .DEN_BITS(DEN_BITS), .Q_BITS(COUNT_BITS)
	) u_cmp_one (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(nd_one_s1),
		.divisor(dn_one_s1), .busy(busy[1]), .quotient(cmp_one)
	);

	kpse_div #(
		.DVD_BITS(NUM_BITS), .DEN_BITS(VALUE_BITS), .Q_BITS(COUNT_BITS)
	) u_per_two (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(num_q),
		.divisor(freq_two), .busy(busy[2]), .quotient(per_two)
	);

	kpse_div #(
		.DVD_BITS(PROD_BITS), .DEN_BITS(DEN_BITS), .Q_BITS(COUNT_BITS)
	) u_cmp_two (
		.clk(clk), .arst_n(arst_n), .start(start), .dividend(nd_two_s1),
		.divisor(dn_two_s1), .busy(busy[3]), .quotient(cmp_two)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			period_one_q  <= FIELD_BITS'(per_one);
			compare_one_q <= FIELD_BITS'(cmp_one);
			period_two_q  <= FIELD_BITS'(per_two);
			compare_two_q <= FIELD_BITS'(cmp_two);
			echo_kind_q   <= echo_kind_c;
			echo_value_q  <= echo_value_c;
		end
	end

	assign result_valid = result_valid_q;
	assign period_one   = period_one_q;
	assign compare_one  = compare_one_q;
	assign period_two   = period_two_q;
	assign compare_two  = compare_two_q;
	assign echo_kind    = echo_kind_q;
	assign echo_value   = echo_value_q;

endmodule

// File: sv/kpse_chk.sv
// Port-level checker for the keypad set-point entry block, bound to the top level.
// Depends on kpse_pkg and keypad_pwm_setpoint_entry_defines.svh.
`include "keypad_pwm_setpoint_entry_defines.svh"

module kpse_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            key_valid,
	input logic                            key_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic [kpse_pkg::FIELD_BITS-1:0] period_one,
	input logic [kpse_pkg::FIELD_BITS-1:0] compare_one,
	input logic [kpse_pkg::FIELD_BITS-1:0] period_two,
	input logic [kpse_pkg::FIELD_BITS-1:0] compare_two,
	input logic [1:0]                      echo_kind,
	input logic [7:0]                      echo_value
);
	import kpse_pkg::*;

	logic [4*FIELD_BITS+9:0] result_bus;
	logic                    digit_char;

	assign result_bus = {period_one, compare_one, period_two, compare_two, echo_kind, echo_value};
	assign digit_char = (echo_value >= ASCII_ZERO) && (echo_value <= ASCII_NINE);

	`CHK_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_bus))
	`CHK_NEXT(a_one_at_a_time, key_valid && key_ready, !key_ready)
	`CHK_NEXT(a_no_instant_result, key_valid && key_ready, !$rose(result_valid))
	`CHK_NOW(a_quiet_echo, result_valid && echo_kind == ECHO_NONE, echo_value == 8'd0)
	`CHK_NOW(a_digit_echo, result_valid && echo_kind == ECHO_DIGIT, digit_char)

endmodule

bind keypad_pwm_setpoint_entry kpse_chk u_kpse_chk (.*);

// File: bench/kpse_checker.sv
// Checker for the keypad set-point entry block: follows the key, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on kpse_pkg.
module kpse_checker #(
	parameter int VALUE_BITS = 20,
	parameter int COUNT_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [kpse_pkg::NUM_BITS-1:0]   cfg_data,
	input  logic                            key_valid,
	input  logic                            key_ready,
	input  logic [kpse_pkg::KEY_BITS-1:0]   key_code,
	input  logic                            result_valid,
	input  logic                            result_ready,
	input  logic [kpse_pkg::FIELD_BITS-1:0] period_one,
	input  logic [kpse_pkg::FIELD_BITS-1:0] compare_one,
	input  logic [kpse_pkg::FIELD_BITS-1:0] period_two,
	input  logic [kpse_pkg::FIELD_BITS-1:0] compare_two,
	input  logic [1:0]                      echo_kind,
	input  logic [7:0]                      echo_value,
	output int                              fail_count,
	output int                              pending
);
	import kpse_pkg::*;

	localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;
	localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
	// key index 0 in the low nibble
	localparam logic [63:0] CODE_TABLE = 64'hDF0E_C987_B654_A321;
	localparam logic [31:0] CURSOR_TABLE = 32'hCDC3_8D83;

	typedef struct packed {
		logic [FIELD_BITS-1:0] period_one;
		logic [FIELD_BITS-1:0] compare_one;
		logic [FIELD_BITS-1:0] period_two;
		logic [FIELD_BITS-1:0] compare_two;
		echo_kind_t            kind;
		logic [7:0]            echo_byte;
	} pwm_result_t;

	logic [NUM_BITS-1:0]   ticks_per_second;
	logic [3:0]            open_entries;
	logic [VALUE_BITS-1:0] entry_value;
	logic [VALUE_BITS-1:0] setpoint [4];
	pwm_result_t           expected_q [$];

	function automatic logic [VALUE_BITS-1:0] clip_value(input logic [63:0] v);
		return (v > VALUE_MAX) ? VALUE_MAX[VALUE_BITS-1:0] : v[VALUE_BITS-1:0];
	endfunction

	function automatic logic [FIELD_BITS-1:0] clip_count(input logic [63:0] v);
		return (v > COUNT_MAX) ? COUNT_MAX[FIELD_BITS-1:0] : v[FIELD_BITS-1:0];
	endfunction

	function automatic void channel_counts(input logic [VALUE_BITS-1:0] freq,
			input logic [VALUE_BITS-1:0] duty, output logic [FIELD_BITS-1:0] period,
			output logic [FIELD_BITS-1:0] compare);
		logic [63:0] num;
		num = 64'(ticks_per_second);
		if (freq == '0) begin
			period = '0;
			compare = '0;
		end else begin
			period = clip_count(num / 64'(freq));
			compare = clip_count((num * 64'(duty)) / (64'(freq) * 64'(PERCENT)));
		end
	endfunction

	function automatic pwm_result_t apply_key(input logic [KEY_BITS-1:0] key);
		pwm_result_t           r;
		logic [3:0]            code;
		logic [1:0]            slot;
		logic [FIELD_BITS-1:0] per, cmp;
		int                    idx;
		r = '0;
		r.kind = ECHO_NONE;
		if (key != KEY_NONE && key <= KEY_LAST) begin
			idx = int'(key) - 1;
			code = CODE_TABLE[idx*4 +: 4];
			if (code >= CODE_TOGGLE_FIRST && code <= CODE_TOGGLE_LAST) begin
				slot = 2'(code - CODE_TOGGLE_FIRST);
				if (open_entries[slot]) begin
					setpoint[slot] = entry_value;
				end else begin
					r.kind = ECHO_CURSOR;
					r.echo_byte = CURSOR_TABLE[int'(slot)*8 +: 8];
					entry_value = '0;
				end
				open_entries[slot] = ~open_entries[slot];
			end else if (code == CODE_DOUBLE) begin
				setpoint[SLOT_FREQ_ONE] = clip_value(64'(setpoint[SLOT_FREQ_ONE]) * 64'd2);
				setpoint[SLOT_FREQ_TWO] = clip_value(64'(setpoint[SLOT_FREQ_TWO]) * 64'd2);
			end else if (code == CODE_RAISE) begin
				setpoint[SLOT_DUTY_ONE] = clip_value(64'(setpoint[SLOT_DUTY_ONE]) + 64'(DUTY_STEP));
				setpoint[SLOT_DUTY_TWO] = clip_value(64'(setpoint[SLOT_DUTY_TWO]) + 64'(DUTY_STEP));
			end else if (code <= CODE_DIGIT_LAST && open_entries != '0) begin
				r.kind = ECHO_DIGIT;
				r.echo_byte = ASCII_ZERO + 8'(code);
				entry_value = clip_value(64'(entry_value) * 64'd10 + 64'(code));
			end
		end
		channel_counts(setpoint[SLOT_FREQ_ONE], setpoint[SLOT_DUTY_ONE], per, cmp);
		r.period_one = per;
		r.compare_one = cmp;
		channel_counts(setpoint[SLOT_FREQ_TWO], setpoint[SLOT_DUTY_TWO], per, cmp);
		r.period_two = per;
		r.compare_two = cmp;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [FIELD_BITS-1:0] want,
			input logic [FIELD_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		pwm_result_t want;
		if (!arst_n) begin
			ticks_per_second = NUMERATOR_RESET;
			open_entries = '0;
			entry_value = '0;
			for (int s = 0; s < 4; s++) setpoint[s] = '0;
			expected_q.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with no result expected");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("period_one", want.period_one, period_one);
					check_field("compare_one", want.compare_one, compare_one);
					check_field("period_two", want.period_two, period_two);
					check_field("compare_two", want.compare_two, compare_two);
					check_field("echo_kind", FIELD_BITS'(want.kind), FIELD_BITS'(echo_kind));
					check_field("echo_value", FIELD_BITS'(want.echo_byte),
						FIELD_BITS'(echo_value));
				end
			end
			if (cfg_write) ticks_per_second = cfg_data;
			if (key_valid && key_ready) expected_q.push_back(apply_key(key_code));
		end
		pending = expected_q.size();
	end

endmodule

// File: bench/tb_keypad_pwm_setpoint_entry.sv
// Top of the keypad set-point entry testbench: clock, reset, key traffic,
// result stalls, configuration phases, watchdog and verdict.
// Depends on kpse_pkg, kpse_checker and keypad_pwm_setpoint_entry.
module tb_keypad_pwm_setpoint_entry;
	import kpse_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [KEY_BITS-1:0] KEY_DOUBLE = 5'd13;
	localparam logic [KEY_BITS-1:0] KEY_RAISE = 5'd15;
	localparam logic [KEY_BITS-1:0] KEY_CODE_MAX = 5'd31;
	localparam logic [NUM_BITS-1:0] NUMERATOR_MIN = 24'd1;
	localparam logic [NUM_BITS-1:0] NUMERATOR_MAX = 24'hFFFFFF;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_BLOCKS
	} ready_pattern_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [NUM_BITS-1:0]   cfg_data;
	logic                  key_valid;
	logic                  key_ready;
	logic [KEY_BITS-1:0]   key_code;
	logic                  result_valid;
	logic                  result_ready;
	logic [FIELD_BITS-1:0] period_one;
	logic [FIELD_BITS-1:0] compare_one;
	logic [FIELD_BITS-1:0] period_two;
	logic [FIELD_BITS-1:0] compare_two;
	logic [1:0]            echo_kind;
	logic [7:0]            echo_value;

	int             fail_count;
	int             pending;
	int             burst_left;
	int             stall_cycles;
	int             mode_left;
	ready_pattern_t ready_mode;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	keypad_pwm_setpoint_entry i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.key_valid    (key_valid),
		.key_ready    (key_ready),
		.key_code     (key_code),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.period_one   (period_one),
		.compare_one  (compare_one),
		.period_two   (period_two),
		.compare_two  (compare_two),
		.echo_kind    (echo_kind),
		.echo_value   (echo_value)
	);

	kpse_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.key_valid    (key_valid),
		.key_ready    (key_ready),
		.key_code     (key_code),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.period_one   (period_one),
		.compare_one  (compare_one),
		.period_two   (period_two),
		.compare_two  (compare_two),
		.echo_kind    (echo_kind),
		.echo_value   (echo_value),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	function automatic logic [KEY_BITS-1:0] digit_key(input int digit);
		logic [KEY_BITS-1:0] k;
		case (digit)
			0:       k = 5'd14;
			1:       k = 5'd1;
			2:       k = 5'd2;
			3:       k = 5'd3;
			4:       k = 5'd5;
			5:       k = 5'd6;
			6:       k = 5'd7;
			7:       k = 5'd9;
			8:       k = 5'd10;
			default: k = 5'd11;
		endcase
		return k;
	endfunction

	function automatic logic [KEY_BITS-1:0] toggle_key(input logic [1:0] slot);
		logic [KEY_BITS-1:0] k;
		case (slot)
			SLOT_FREQ_ONE: k = 5'd4;
			SLOT_DUTY_ONE: k = 5'd8;
			SLOT_FREQ_TWO: k = 5'd12;
			default:       k = 5'd16;
		endcase
		return k;
	endfunction

	task automatic send_key(input logic [KEY_BITS-1:0] key);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				key_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		key_valid <= 1'b1;
		key_code <= key;
		do @(posedge clk); while (!key_ready);
		burst_left--;
	endtask

	task automatic set_numerator(input logic [NUM_BITS-1:0] value);
		@(negedge clk);
		key_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		burst_left = 0;
	endtask

	task automatic run_random(input int count);
		int sent, pick, slot, other, ndig;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			slot = $urandom_range(0, 3);
			ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
			if (pick < 60) begin
				send_key(toggle_key(2'(slot)));
				repeat (ndig) send_key(digit_key($urandom_range(0, 9)));
				send_key(toggle_key(2'(slot)));
				sent += ndig + 2;
			end else if (pick < 68) begin
				other = (slot + $urandom_range(1, 3)) % 4;
				send_key(toggle_key(2'(slot)));
				send_key(digit_key($urandom_range(0, 9)));
				send_key(toggle_key(2'(other)));
				repeat (ndig) send_key(digit_key($urandom_range(0, 9)));
				send_key(toggle_key(2'(slot)));
				send_key(toggle_key(2'(other)));
				sent += ndig + 5;
			end else if (pick < 76) begin
				send_key(KEY_DOUBLE);
				sent++;
			end else if (pick < 84) begin
				send_key(KEY_RAISE);
				sent++;
			end else if (pick < 92) begin
				if ($urandom_range(0, 1) == 0) send_key(KEY_NONE);
				else send_key(KEY_BITS'($urandom_range(KEY_LAST + 1, KEY_CODE_MAX)));
				sent++;
			end else begin
				send_key(KEY_BITS'($urandom_range(1, KEY_LAST)));
				sent++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_pattern_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 300);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			READY_ALWAYS: result_ready <= 1'b1;
			READY_COIN:   result_ready <= ($urandom_range(0, 1) == 0);
			READY_SPARSE: result_ready <= ($urandom_range(0, 7) == 0);
			default:      result_ready <= mode_left[3];
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (key_valid && key_ready) || (result_valid && result_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		key_valid = 1'b0;
		key_code = KEY_NONE;
		result_ready = 1'b0;
		burst_left = 0;
		mode_left = 0;
		stall_cycles = 0;
		ready_mode = READY_ALWAYS;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_key(KEY_NONE);
		send_key(KEY_CODE_MAX);
		send_key(digit_key(7));
		send_key(toggle_key(SLOT_FREQ_ONE));
		send_key(digit_key(1));
		send_key(digit_key(0));
		send_key(digit_key(0));
		send_key(toggle_key(SLOT_FREQ_ONE));
		send_key(toggle_key(SLOT_DUTY_ONE));
		send_key(digit_key(5));
		send_key(digit_key(0));
		send_key(toggle_key(SLOT_DUTY_ONE));
		// two entries open at once, then overflow the shared value
		send_key(toggle_key(SLOT_FREQ_TWO));
		send_key(toggle_key(SLOT_DUTY_TWO));
		repeat (7) send_key(digit_key(9));
		send_key(toggle_key(SLOT_FREQ_TWO));
		send_key(toggle_key(SLOT_DUTY_TWO));
		send_key(KEY_DOUBLE);
		send_key(KEY_RAISE);
		// tiny frequency against the largest duty overflows the compare count
		send_key(toggle_key(SLOT_FREQ_TWO));
		send_key(digit_key(2));
		send_key(toggle_key(SLOT_FREQ_TWO));

		run_random(500);
		set_numerator(NUMERATOR_MIN);
		run_random(350);
		set_numerator(NUMERATOR_MAX);
		run_random(350);
		set_numerator(NUM_BITS'($urandom_range(2, NUMERATOR_MAX - 1)));
		run_random(350);
		set_numerator(NUMERATOR_RESET);
		run_random(450);

		@(negedge clk);
		key_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
